### hdl/ptrs_pkg.sv
package ptrs_pkg;

   // Phase codes as they appear on the result channel.
   localparam logic [2:0] PHASE_IDLE     = 3'd0;
   localparam logic [2:0] PHASE_DEBOUNCE = 3'd1;
   localparam logic [2:0] PHASE_FIRST    = 3'd2;
   localparam logic [2:0] PHASE_SENSOR   = 3'd3;
   localparam logic [2:0] PHASE_LAST     = 3'd4;

   // Register indexes on the configuration port (byte address is 4 times the index).
   localparam int unsigned CsrAddrWidth = 5;
   localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
   localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
   localparam logic [2:0] REG_R1_ON       = 3'd2;
   localparam logic [2:0] REG_R1_OFF      = 3'd3;
   localparam logic [2:0] REG_R2_ON       = 3'd4;
   localparam logic [2:0] REG_R2_OFF      = 3'd5;

   // Register reset values.
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [7:0]  R1_ON_RESET       = 8'd2;
   localparam logic [7:0]  R1_OFF_RESET      = 8'd3;
   localparam logic [7:0]  R2_ON_RESET       = 8'd2;
   localparam logic [7:0]  R2_OFF_RESET      = 8'd8;

   // Sequencer state, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DEBOUNCE = 5'b00010,
      ST_FIRST    = 5'b00100,
      ST_SENSOR   = 5'b01000,
      ST_LAST     = 5'b10000
   } seq_state_type;

   // One result item.
   typedef struct packed {
      logic       relay1_n;
      logic       relay2_n;
      logic [2:0] phase;
   } result_type;

   // Maps the one-hot state onto the external phase code.
   function automatic logic [2:0] phase_code(seq_state_type st);
      logic [2:0] code;
      unique case (st)
         ST_DEBOUNCE: code = PHASE_DEBOUNCE;
         ST_FIRST:    code = PHASE_FIRST;
         ST_SENSOR:   code = PHASE_SENSOR;
         ST_LAST:     code = PHASE_LAST;
         default:     code = PHASE_IDLE;
      endcase
      return code;
   endfunction

endpackage

### hdl/pedal_triggered_relay_sequencer.sv
// Pedal-triggered relay sequencer.
// Each transfer on the req_ channel is one millisecond sample of the pedal and
// sensor levels, both active low. Every accepted sample produces exactly one
// result transfer on the rsp_ channel carrying both relay drives (active low)
// and the phase code after that sample has been applied.
// Each result is registered, in the output register or behind it in the skid register.
// Throughput is one sample per cycle while req_stall is low; the state
// update is a single pass of counter and compare logic from the state registers.
// When the receiver stalls, one more sample is still taken into a skid register;
// req_stall rises only while that skid register is full, and drops again as soon
// as the receiver takes the waiting result.
// Reset (synchronous, active high) returns the sequencer to idle with both
// relays off, clears all counters and empties the result registers. The
// configuration registers return to their defaults (500 ms tick, 50 ms debounce,
// relay 1 on/off at 2/3, relay 2 on/off at 2/8). The user must write configuration
// via the csr_ port only while no samples are in flight; the block does not enforce it.
module pedal_triggered_relay_sequencer
   import ptrs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Sample channel.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_pedal_n,
   input  logic                    req_sensor_n,
   // Result channel.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_relay1_n,
   output logic                    rsp_relay2_n,
   output logic [2:0]              rsp_phase,
   // Configuration port.
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   // Configuration registers.
   logic [15:0] half_period_ff;
   logic [15:0] debounce_ff;
   logic [7:0]  r1_on_ff;
   logic [7:0]  r1_off_ff;
   logic [7:0]  r2_on_ff;
   logic [7:0]  r2_off_ff;

   // Sequencer state.
   seq_state_type state_ff, state_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [15:0]   debounce_left_ff, debounce_left_in;
   logic [7:0]    half_ticks_ff, half_ticks_in;
   logic          count_enable_ff, count_enable_in;
   logic          relay1_ff, relay1_in;
   logic          relay2_ff, relay2_in;

   // Output and skid registers.
   logic       out_valid_ff;
   result_type out_ff;
   logic       skid_valid_ff;
   result_type skid_ff;

   logic       csr_write;
   logic [2:0] csr_index;
   logic       accept;
   logic       pop;
   result_type result;

   // Intermediate values of the single update pass.
   logic [15:0] idle_elapsed;
   logic [15:0] run_elapsed;
   logic        tick;
   logic [7:0]  run_ticks;
   logic [15:0] debounce_dec;
   logic        pedal_low;
   logic        sensor_low;
   logic        sensor_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CsrAddrWidth-1:2];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         debounce_ff    <= DEBOUNCE_RESET;
         r1_on_ff       <= R1_ON_RESET;
         r1_off_ff      <= R1_OFF_RESET;
         r2_on_ff       <= R2_ON_RESET;
         r2_off_ff      <= R2_OFF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HALF_PERIOD: half_period_ff <= csr_pwdata[15:0];
            REG_DEBOUNCE:    debounce_ff    <= csr_pwdata[15:0];
            REG_R1_ON:       r1_on_ff       <= csr_pwdata[7:0];
            REG_R1_OFF:      r1_off_ff      <= csr_pwdata[7:0];
            REG_R2_ON:       r2_on_ff       <= csr_pwdata[7:0];
            REG_R2_OFF:      r2_off_ff      <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_index)
         REG_HALF_PERIOD: csr_prdata = {16'd0, half_period_ff};
         REG_DEBOUNCE:    csr_prdata = {16'd0, debounce_ff};
         REG_R1_ON:       csr_prdata = {24'd0, r1_on_ff};
         REG_R1_OFF:      csr_prdata = {24'd0, r1_off_ff};
         REG_R2_ON:       csr_prdata = {24'd0, r2_on_ff};
         REG_R2_OFF:      csr_prdata = {24'd0, r2_off_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Handshakes: the skid register being full is the only reason to stall.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;

   assign pedal_low  = !req_pedal_n;
   assign sensor_low = !req_sensor_n;

   // Millisecond counter outside a run saturates at the period.
   assign idle_elapsed = (elapsed_ff >= half_period_ff) ? half_period_ff
                                                        : elapsed_ff + 16'd1;

   // Millisecond counter inside a run, with the tick and half-tick count.
   always_comb begin
      run_elapsed = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
      tick        = (run_elapsed >= half_period_ff);
      run_ticks   = half_ticks_ff;
      if (tick) begin
         run_elapsed = 16'd0;
         run_ticks   = count_enable_ff ? 8'(half_ticks_ff + 8'd1) : 8'd0;
      end
   end

   assign debounce_dec = (debounce_left_ff != 16'd0) ? debounce_left_ff - 16'd1
                                                     : debounce_left_ff;
   assign sensor_count = count_enable_ff || sensor_low;

   // Next state for one sample.
   always_comb begin
      state_in         = state_ff;
      elapsed_in       = elapsed_ff;
      debounce_left_in = debounce_left_ff;
      half_ticks_in    = half_ticks_ff;
      count_enable_in  = count_enable_ff;
      relay1_in        = relay1_ff;
      relay2_in        = relay2_ff;
      unique case (state_ff) inside
         ST_DEBOUNCE: begin
            elapsed_in       = idle_elapsed;
            debounce_left_in = debounce_dec;
            if (debounce_dec == 16'd0) begin
               if (pedal_low) begin
                  count_enable_in = 1'b1;
                  state_in        = ST_FIRST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIRST, ST_LAST: begin
            // Relay 1 pulse; off wins over on when both counts match.
            elapsed_in    = run_elapsed;
            half_ticks_in = run_ticks;
            if (run_ticks == r1_on_ff) begin
               relay1_in = 1'b0;
            end
            if (run_ticks == r1_off_ff) begin
               relay1_in = 1'b1;
            end
            if (run_ticks > r1_off_ff) begin
               count_enable_in = 1'b0;
               half_ticks_in   = 8'd0;
               state_in        = (state_ff == ST_FIRST) ? ST_SENSOR : ST_IDLE;
            end
         end
         ST_SENSOR: begin
            // Counting latches on at the first sensor hit.
            elapsed_in      = run_elapsed;
            half_ticks_in   = run_ticks;
            count_enable_in = sensor_count;
            if (sensor_count) begin
               if (run_ticks == r2_on_ff) begin
                  relay2_in = 1'b0;
               end
               if (run_ticks == r2_off_ff) begin
                  relay2_in     = 1'b1;
                  half_ticks_in = 8'd0;
                  state_in      = ST_LAST;
               end
            end
         end
         default: begin
            state_in   = ST_IDLE;
            elapsed_in = idle_elapsed;
            if (pedal_low) begin
               debounce_left_in = debounce_ff;
               state_in         = ST_DEBOUNCE;
            end
         end
      endcase
   end

   assign result.relay1_n = relay1_in;
   assign result.relay2_n = relay2_in;
   assign result.phase    = phase_code(state_in);

   // State registers advance once per accepted sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         elapsed_ff       <= 16'd0;
         debounce_left_ff <= 16'd0;
         half_ticks_ff    <= 8'd0;
         count_enable_ff  <= 1'b0;
         relay1_ff        <= 1'b1;
         relay2_ff        <= 1'b1;
      end else if (accept) begin
         state_ff         <= state_in;
         elapsed_ff       <= elapsed_in;
         debounce_left_ff <= debounce_left_in;
         half_ticks_ff    <= half_ticks_in;
         count_enable_ff  <= count_enable_in;
         relay1_ff        <= relay1_in;
         relay2_ff        <= relay2_in;
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_relay1_n = out_ff.relay1_n;
   assign rsp_relay2_n = out_ff.relay2_n;
   assign rsp_phase    = out_ff.phase;

   // The skid register only fills behind a waiting result.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   // Relay 2 is energized only during the sensor phase.
   assert property (@(posedge clock) disable iff (reset)
      !relay2_ff |-> (state_ff == ST_SENSOR))
      else $error("relay 2 energized outside the sensor phase");

   // Reported phase codes stay within the defined range.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.phase <= PHASE_LAST))
      else $error("result carries an undefined phase code");

   // A result that waits while another sample arrives lands in the skid register.
   assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("sample accepted under stall was not captured");

   // Reset empties the result path.
   assert property (@(posedge clock) reset |=> !out_valid_ff && !skid_valid_ff)
      else $error("result registers not empty after reset");

endmodule

### tb/sv/pedal_triggered_relay_sequencer_tb.sv
module pedal_triggered_relay_sequencer_tb
   import ptrs_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ROUNDS = 10;
   localparam int SAMPLES_PER_ROUND = 85;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_pedal_n = 1'b1;
   logic                    req_sensor_n = 1'b1;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_relay1_n;
   logic                    rsp_relay2_n;
   logic [2:0]              rsp_phase;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // Settings mirrored from the register file.
   logic [15:0] cfg_half_period;
   logic [15:0] cfg_debounce;
   logic [7:0]  cfg_r1_on;
   logic [7:0]  cfg_r1_off;
   logic [7:0]  cfg_r2_on;
   logic [7:0]  cfg_r2_off;

   // Sequencer state as predicted.
   logic [2:0]  seq_phase;
   logic [15:0] ms_elapsed;
   logic [15:0] debounce_remaining;
   logic [7:0]  tick_count;
   logic        ticking;
   logic        relay1_drive;
   logic        relay2_drive;

   result_type expected_outputs[$];
   int         error_count = 0;
   int         cycle_count = 0;

   // Receiver stall pattern state.
   int stall_mode = 0;
   int stall_span = 0;

   pedal_triggered_relay_sequencer dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Millisecond counter while idle or debouncing: it grows and saturates at the period.
   function automatic void hold_idle_timer();
      if (ms_elapsed >= cfg_half_period)
         ms_elapsed = cfg_half_period;
      else
         ms_elapsed = ms_elapsed + 16'd1;
   endfunction

   // Millisecond counter during a run: a tick steps or clears the half-tick count.
   function automatic void run_timer_step();
      if (ms_elapsed != 16'hFFFF)
         ms_elapsed = ms_elapsed + 16'd1;
      if (ms_elapsed >= cfg_half_period) begin
         ms_elapsed = 16'd0;
         tick_count = ticking ? tick_count + 8'd1 : 8'd0;
      end
   endfunction

   // One millisecond of a relay-1 pulse; returns 1 when the pulse phase is over.
   function automatic bit relay1_pulse_step();
      run_timer_step();
      if (tick_count == cfg_r1_on)
         relay1_drive = 1'b0;
      if (tick_count == cfg_r1_off)
         relay1_drive = 1'b1;
      if (tick_count > cfg_r1_off) begin
         ticking = 1'b0;
         tick_count = 8'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one millisecond sample and returns the outputs that follow it.
   function automatic result_type predict_relay_outputs(input logic pedal_n,
                                                        input logic sensor_n);
      result_type outputs;
      case (seq_phase)
         PHASE_DEBOUNCE: begin
            hold_idle_timer();
            if (debounce_remaining != 16'd0)
               debounce_remaining = debounce_remaining - 16'd1;
            if (debounce_remaining == 16'd0) begin
               if (!pedal_n) begin
                  ticking = 1'b1;
                  seq_phase = PHASE_FIRST;
               end else begin
                  seq_phase = PHASE_IDLE;
               end
            end
         end
         PHASE_FIRST: begin
            if (relay1_pulse_step())
               seq_phase = PHASE_SENSOR;
         end
         PHASE_SENSOR: begin
            run_timer_step();
            if (!sensor_n)
               ticking = 1'b1;
            if (ticking) begin
               if (tick_count == cfg_r2_on)
                  relay2_drive = 1'b0;
               if (tick_count == cfg_r2_off) begin
                  relay2_drive = 1'b1;
                  tick_count = 8'd0;
                  seq_phase = PHASE_LAST;
               end
            end
         end
         PHASE_LAST: begin
            if (relay1_pulse_step())
               seq_phase = PHASE_IDLE;
         end
         default: begin
            seq_phase = PHASE_IDLE;
            hold_idle_timer();
            if (!pedal_n) begin
               debounce_remaining = cfg_debounce;
               seq_phase = PHASE_DEBOUNCE;
            end
         end
      endcase
      outputs.relay1_n = relay1_drive;
      outputs.relay2_n = relay2_drive;
      outputs.phase = seq_phase;
      return outputs;
   endfunction

   function automatic void reset_prediction();
      cfg_half_period = HALF_PERIOD_RESET;
      cfg_debounce = DEBOUNCE_RESET;
      cfg_r1_on = R1_ON_RESET;
      cfg_r1_off = R1_OFF_RESET;
      cfg_r2_on = R2_ON_RESET;
      cfg_r2_off = R2_OFF_RESET;
      seq_phase = PHASE_IDLE;
      ms_elapsed = 16'd0;
      debounce_remaining = 16'd0;
      tick_count = 8'd0;
      ticking = 1'b0;
      relay1_drive = 1'b1;
      relay2_drive = 1'b1;
   endfunction

   // Reads one register and compares it with the value it should hold.
   task automatic check_register(input logic [2:0] idx, input logic [15:0] want);
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== {16'd0, want}) begin
         $error("csr_prdata (register %0d): expected %0d, actual %0d", idx, want, got);
         error_count++;
      end
   endtask

   // Writes one register, mirrors it and reads it back.
   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_HALF_PERIOD: cfg_half_period = value;
         REG_DEBOUNCE:    cfg_debounce = value;
         REG_R1_ON:       cfg_r1_on = value[7:0];
         REG_R1_OFF:      cfg_r1_off = value[7:0];
         REG_R2_ON:       cfg_r2_on = value[7:0];
         REG_R2_OFF:      cfg_r2_off = value[7:0];
         default: ;
      endcase
      check_register(idx, value);
   endtask

   task automatic write_settings(input logic [15:0] half_period, input logic [15:0] debounce,
                                 input logic [7:0] r1_on, input logic [7:0] r1_off,
                                 input logic [7:0] r2_on, input logic [7:0] r2_off);
      write_register(REG_HALF_PERIOD, half_period);
      write_register(REG_DEBOUNCE, debounce);
      write_register(REG_R1_ON, {8'd0, r1_on});
      write_register(REG_R1_OFF, {8'd0, r1_off});
      write_register(REG_R2_ON, {8'd0, r2_on});
      write_register(REG_R2_OFF, {8'd0, r2_off});
   endtask

   // Presents one sample and holds it until the transfer takes place.
   task automatic send_sample(input logic pedal_n, input logic sensor_n);
      req_valid <= 1'b1;
      req_pedal_n <= pedal_n;
      req_sensor_n <= sensor_n;
      do @(posedge clock); while (req_stall);
      expected_outputs.push_back(predict_relay_outputs(pedal_n, sensor_n));
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Lets every outstanding result arrive before touching the registers.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_register_defaults();
      check_register(REG_HALF_PERIOD, HALF_PERIOD_RESET);
      check_register(REG_DEBOUNCE, DEBOUNCE_RESET);
      check_register(REG_R1_ON, {8'd0, R1_ON_RESET});
      check_register(REG_R1_OFF, {8'd0, R1_OFF_RESET});
      check_register(REG_R2_ON, {8'd0, R2_ON_RESET});
      check_register(REG_R2_OFF, {8'd0, R2_OFF_RESET});
   endtask

   // Zero debounce and equal on and off counts: relay 1 never energizes.
   // The sensor is released once relay-2 counting has begun.
   task automatic test_short_run_equal_counts();
      drain_results();
      write_settings(16'd1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b1);
   endtask

   // An on count one past the off count turns relay 1 on as the pulse ends.
   task automatic test_relay_left_on();
      drain_results();
      write_settings(16'd1, 16'd0, 8'd1, 8'd0, 8'd1, 8'd2);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b1);
   endtask

   // A pedal released before the debounce wait ends returns to idle.
   task automatic test_debounce_release();
      drain_results();
      write_register(REG_DEBOUNCE, 16'd2);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
   endtask

   // Largest settings; the run then parks in the first pulse on a long period.
   task automatic test_largest_settings();
      drain_results();
      write_settings(16'hFFFF, 16'hFFFF, 8'd255, 8'd254, 8'd255, 8'd255);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      drain_results();
      write_register(REG_DEBOUNCE, 16'd1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
   endtask

   function automatic logic [7:0] random_count(input logic [7:0] top);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 8)
         return 8'($urandom_range(0, 5));
      else if (pick == 8)
         return 8'($urandom_range(0, top));
      return top;
   endfunction

   // Rounds of random settings, each followed by press and sensor sequences.
   task automatic test_random_sequences();
      logic [15:0] half_period;
      logic [15:0] debounce;
      logic        pedal_level;
      logic        sensor_level;
      int          pedal_run;
      int          sensor_run;
      int          burst_left;
      int          pick;
      pedal_run = 0;
      sensor_run = 0;
      pedal_level = 1'b1;
      sensor_level = 1'b1;
      burst_left = $urandom_range(1, 40);
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         drain_results();
         pick = $urandom_range(0, 19);
         if (pick < 14)
            half_period = 16'($urandom_range(1, 3));
         else if (pick < 19)
            half_period = 16'($urandom_range(4, 20));
         else
            half_period = ($urandom_range(0, 1) == 0) ? 16'd500 : 16'hFFFF;
         debounce = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 4))
                                                : 16'($urandom_range(5, 40));
         write_settings(half_period, debounce, random_count(8'd255), random_count(8'd254),
                        random_count(8'd255), random_count(8'd255));
         for (int n = 0; n < SAMPLES_PER_ROUND; n++) begin
            // Pedal presses are mostly held long enough to pass the debounce wait.
            if (pedal_run == 0) begin
               pedal_level = ($urandom_range(0, 99) < 65) ? 1'b0 : 1'b1;
               pedal_run = pedal_level ? $urandom_range(1, 6)
                                       : $urandom_range(1, int'(cfg_debounce) + 4);
            end
            if (sensor_run == 0) begin
               sensor_level = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
               sensor_run = sensor_level ? $urandom_range(1, 10) : $urandom_range(1, 4);
            end
            pedal_run--;
            sensor_run--;
            send_sample(pedal_level, sensor_level);
            burst_left--;
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0)
                  pause_sender($urandom_range(1, 8));
               burst_left = $urandom_range(1, 40);
            end
         end
      end
   endtask

   // Receiver stall: runs of free flow, light or heavy random stall and full stall.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
      end
      stall_span--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   // Each result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $error("result transfer with no sample outstanding");
            error_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_relay1_n !== want.relay1_n) begin
               $error("relay1_n: expected %0d, actual %0d", want.relay1_n, rsp_relay1_n);
               error_count++;
            end
            if (rsp_relay2_n !== want.relay2_n) begin
               $error("relay2_n: expected %0d, actual %0d", want.relay2_n, rsp_relay2_n);
               error_count++;
            end
            if (rsp_phase !== want.phase) begin
               $error("phase: expected %0d, actual %0d", want.phase, rsp_phase);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset_prediction();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_defaults();
      test_short_run_equal_counts();
      test_relay_left_on();
      test_debounce_release();
      test_largest_settings();
      test_random_sequences();
      drain_results();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
